[rtl/signed_int_to_decimal_text_top_assert.svh]
// Assertion macros used by the port-level checker file.
`ifndef SIGNED_INT_TO_DECIMAL_TEXT_TOP_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_TEXT_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define SITD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define SITD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/sitd_pkg.sv]
// Shared constants, state type and control structs for the decimal text converter.
package sitd_pkg;

   localparam int VALUE_W     = 32;
   localparam int CHAR_W      = 7;
   localparam int DIGIT_W     = 4;
   localparam int MAX_DIGITS  = 10;
   localparam int DIG_IDX_W   = $clog2(MAX_DIGITS);
   localparam int DIG_CNT_W   = $clog2(MAX_DIGITS + 1);
   localparam int PROD_W      = 2 * VALUE_W;
   localparam int RECIP_SHIFT = 35;
   localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

   // floor(x * RECIP / 2^35) == floor(x / 10) for every 32-bit x
   localparam logic [VALUE_W-1:0] RECIP      = 32'hCCCC_CCCD;
   localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 7'd48;
   localparam logic [CHAR_W-1:0]  CHAR_MINUS = 7'd45;
   localparam logic [CHAR_W-1:0]  CHAR_NINE  = 7'd57;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_SIGN,
      ST_DIGITS
   } state_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic div;
      logic emit_sign;
      logic emit_digit;
   } cmd_type;

   typedef struct packed {
      logic quot_zero;
      logic digits_full;
      logic neg;
      logic out_free;
      logic last_digit;
   } status_type;

endpackage

[rtl/sitd_ctrl.sv]
// Controller state machine: sequences divide steps and character emission.
module sitd_ctrl
   import sitd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div = 1'b1;
            if (status.quot_zero || status.digits_full) begin
               state_in = ST_SIGN;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_SIGN: begin
            if (!status.neg) begin
               state_in = ST_DIGITS;
            end else if (status.out_free) begin
               cmd.emit_sign = 1'b1;
               state_in      = ST_DIGITS;
            end
         end
         ST_DIGITS: begin
            if (status.out_free) begin
               cmd.emit_digit = 1'b1;
               if (status.last_digit) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[rtl/sitd_datapath.sv]
// Datapath: magnitude, reciprocal divide by ten, digit stack and output register.
module sitd_datapath
   import sitd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic signed [VALUE_W-1:0] req_value,
   input  cmd_type                   cmd,
   output status_type                status,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [CHAR_W-1:0]         rsp_character,
   output logic                      rsp_last_char
);

   logic [VALUE_W-1:0]   mag_ff;
   logic [QUOT_W-1:0]    quot_ff;
   logic                 neg_ff;
   logic [DIG_CNT_W-1:0] ndig_ff;
   logic [DIGIT_W-1:0]   dig_ff [MAX_DIGITS];
   logic                 rsp_valid_ff;
   logic [CHAR_W-1:0]    rsp_char_ff;
   logic                 rsp_last_ff;

   logic [VALUE_W-1:0]   raw;
   logic [PROD_W-1:0]    prod;
   logic [DIGIT_W-1:0]   rem;
   logic [DIG_CNT_W-1:0] top_idx;
   logic                 out_free;

   assign raw      = $unsigned(req_value);
   assign prod     = {{VALUE_W{1'b0}}, mag_ff} * {{VALUE_W{1'b0}}, RECIP};
   // remainder = mag - 10*q, only the low nibble matters since it is below ten
   assign rem      = mag_ff[DIGIT_W-1:0] - {quot_ff[0], 3'b000} - {quot_ff[2:0], 1'b0};
   assign top_idx  = ndig_ff - DIG_CNT_W'(1);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         neg_ff <= raw[VALUE_W-1];
         mag_ff <= raw[VALUE_W-1] ? (VALUE_W'(0) - raw) : raw;
      end else if (cmd.div) begin
         mag_ff <= VALUE_W'(quot_ff);
      end
      if (cmd.mul) begin
         quot_ff <= prod[PROD_W-1:RECIP_SHIFT];
      end
      if (cmd.div) begin
         dig_ff[ndig_ff[DIG_IDX_W-1:0]] <= rem;
      end
   end

   // digit count: push during divide, pop during emission
   always_ff @(posedge clock) begin
      if (reset) begin
         ndig_ff <= '0;
      end else if (cmd.load) begin
         ndig_ff <= '0;
      end else if (cmd.div) begin
         ndig_ff <= ndig_ff + DIG_CNT_W'(1);
      end else if (cmd.emit_digit) begin
         ndig_ff <= top_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_sign || cmd.emit_digit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_sign) begin
         rsp_char_ff <= CHAR_MINUS;
         rsp_last_ff <= 1'b0;
      end else if (cmd.emit_digit) begin
         rsp_char_ff <= CHAR_ZERO + CHAR_W'(dig_ff[top_idx[DIG_IDX_W-1:0]]);
         rsp_last_ff <= (top_idx == '0);
      end
   end

   assign status.quot_zero   = (quot_ff == '0);
   assign status.digits_full = (ndig_ff == DIG_CNT_W'(MAX_DIGITS - 1));
   assign status.neg         = neg_ff;
   assign status.out_free    = out_free;
   assign status.last_digit  = (ndig_ff == DIG_CNT_W'(1));

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_char_ff;
   assign rsp_last_char = rsp_last_ff;

endmodule

[rtl/signed_int_to_decimal_text_top.sv]
// Top level of the signed integer to decimal ASCII text converter.
//
//   Channel  Ports                               Moves
//   req      req_valid/req_stall, req_value      one 32-bit signed word in
//   rsp      rsp_valid/rsp_stall, rsp_character, one ASCII character word out
//            rsp_last_char
//
// A value with D decimal digits passes the accept state, a multiply and a divide
// state per digit in the multiply-by-reciprocal divider and the sign state, then
// goes out one character per cycle through the output register unless rsp stalls.
// Synchronous active-high reset clears the controller and the output valid.
// A stalled rsp holds its word and the controller waits; req is stalled
// from accept until the last character is loaded.
module signed_int_to_decimal_text_top
   import sitd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [CHAR_W-1:0]         rsp_character,
   output logic                      rsp_last_char
);

   cmd_type    cmd;
   status_type status;

   sitd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sitd_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_value     (req_value),
      .cmd           (cmd),
      .status        (status),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_character (rsp_character),
      .rsp_last_char (rsp_last_char)
   );

endmodule

[rtl/sitd_checker.sv]
// Port-level checker for the decimal text converter, bound to the top level.
`include "signed_int_to_decimal_text_top_assert.svh"

module sitd_checker
   import sitd_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [CHAR_W-1:0] rsp_character,
   input logic              rsp_last_char
);

   logic            char_legal;
   logic            minus_out;
   logic            req_take;
   logic            rsp_wait;
   logic [CHAR_W:0] rsp_word;

   assign char_legal = (rsp_character == CHAR_MINUS) ||
                       ((rsp_character >= CHAR_ZERO) && (rsp_character <= CHAR_NINE));
   assign minus_out  = rsp_valid && (rsp_character == CHAR_MINUS);
   assign req_take   = req_valid && !req_stall;
   assign rsp_wait   = rsp_valid && rsp_stall;
   assign rsp_word   = {rsp_character, rsp_last_char};

   `SITD_ASSERT_NOW(a_char_legal, rsp_valid, char_legal, "illegal character on rsp")
   `SITD_ASSERT_NOW(a_minus_not_last, minus_out, !rsp_last_char, "minus sign flagged last")
   `SITD_ASSERT_NEXT(a_busy_after_accept, req_take, req_stall, "req not stalled after accept")
   `SITD_ASSERT_NEXT(a_rsp_hold, rsp_wait, rsp_valid && $stable(rsp_word), "stalled rsp changed")

endmodule

bind signed_int_to_decimal_text_top sitd_checker u_sitd_checker (.*);

[test/signed_int_to_decimal_text_top_tb.sv]
// Testbench for the signed integer to decimal text converter, checked per character.
module signed_int_to_decimal_text_top_tb;
   import sitd_pkg::*;

   localparam int QUIET_LIMIT = 1000;
   localparam int TAIL_CYCLES = 40;

   typedef struct packed {
      logic [CHAR_W-1:0] character;
      logic              last_char;
   } text_char_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [CHAR_W-1:0]         rsp_character;
   logic                      rsp_last_char;

   text_char_type expected_text[$];
   text_char_type want;
   int            mismatch_count = 0;
   int            quiet_cycles = 0;
   int unsigned   send_idle_pct = 0;
   int unsigned   rsp_stall_pct = 0;

   signed_int_to_decimal_text_top dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_character (rsp_character),
      .rsp_last_char (rsp_last_char)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // Queue the text of one accepted word, sign first, then digits high to low.
   function automatic void predict_text(input logic [VALUE_W-1:0] raw);
      logic                 negative;
      logic [VALUE_W-1:0]   mag;
      logic [DIGIT_W-1:0]   digs [MAX_DIGITS];
      int                   n;
      text_char_type        c;
      negative = raw[VALUE_W-1];
      mag = negative ? (~raw + 1'b1) : raw;
      n = 0;
      do begin
         digs[n] = DIGIT_W'(mag % 10);
         mag = mag / 10;
         n++;
      end while (mag != 0 && n < MAX_DIGITS);
      if (negative) begin
         c.character = CHAR_MINUS;
         c.last_char = 1'b0;
         expected_text.push_back(c);
      end
      for (int k = n - 1; k >= 0; k--) begin
         c.character = CHAR_ZERO + CHAR_W'(digs[k]);
         c.last_char = (k == 0);
         expected_text.push_back(c);
      end
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_text(req_value);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_text.size() == 0) begin
               $display("%0t: unexpected word: expected none, actual char %0d last %0b",
                        $time, rsp_character, rsp_last_char);
               mismatch_count++;
            end else begin
               want = expected_text.pop_front();
               if (rsp_character !== want.character) begin
                  $display("%0t: character mismatch: expected %0d, actual %0d",
                           $time, want.character, rsp_character);
                  mismatch_count++;
               end
               if (rsp_last_char !== want.last_char) begin
                  $display("%0t: last_char mismatch: expected %0b, actual %0b",
                           $time, want.last_char, rsp_last_char);
                  mismatch_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("signed_int_to_decimal_text_top_tb: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic set_idling(input int unsigned send_pct, input int unsigned stall_pct);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
   endtask

   // Hold the word until the block takes it; idle first at the current rate.
   task automatic send_value(input logic [VALUE_W-1:0] v);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_value <= VALUE_W'($urandom);
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_text.size() != 0);
   endtask

   // Pick a value: full range, a given digit count, or an edge value.
   function automatic logic [VALUE_W-1:0] random_value();
      int unsigned pick;
      int unsigned d;
      longint      lo;
      longint      hi;
      longint      mag;
      logic        negative;
      pick = $urandom_range(99);
      negative = 1'($urandom_range(1));
      if (pick < 40) begin
         return VALUE_W'($urandom);
      end else if (pick < 90) begin
         d = $urandom_range(1, MAX_DIGITS);
         lo = (d == 1) ? 0 : 1;
         for (int i = 1; i < d; i++) lo = lo * 10;
         hi = (d == 1) ? 9 : lo * 10 - 1;
         if (hi > 64'sd2147483647) hi = negative ? 64'sd2147483648 : 64'sd2147483647;
         mag = lo + longint'($urandom) % (hi - lo + 1);
         return negative ? VALUE_W'(-mag) : VALUE_W'(mag);
      end else begin
         case ($urandom_range(4))
            0: return 32'h0000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            3: return negative ? 32'hFFFF_FFFF : 32'h0000_0001;
            default: return negative ? 32'h8000_0001 : 32'h7FFF_FFFE;
         endcase
      end
   endfunction

   task automatic test_directed_values();
      logic [VALUE_W-1:0] vals[$] = '{
         32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd9, -32'sd10,
         32'd99, 32'd100, -32'sd100, 32'd12345, -32'sd67890, 32'd999999999,
         32'd1000000000, -32'sd999999999, -32'sd1000000000, 32'h7FFF_FFFF,
         32'h7FFF_FFFE, 32'h8000_0000, 32'h8000_0001, 32'hAAAA_AAAA, 32'h5555_5555
      };
      foreach (vals[i]) send_value(vals[i]);
   endtask

   task automatic test_random_values(input int count);
      repeat (count) send_value(random_value());
   endtask

   task automatic test_pause_until_drained();
      repeat (4) begin
         repeat ($urandom_range(1, 5)) send_value(random_value());
         wait_drained();
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_idling(0, 0);
      test_directed_values();
      test_random_values(95);

      set_idling(57, 0);
      test_random_values(95);

      set_idling(0, 57);
      test_random_values(95);

      set_idling(32, 32);
      test_random_values(95);
      test_pause_until_drained();

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_text.size() == 0) begin
         $display("signed_int_to_decimal_text_top_tb: clean");
      end else begin
         $display("signed_int_to_decimal_text_top_tb: errors");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl
rtl/sitd_pkg.sv
rtl/sitd_ctrl.sv
rtl/sitd_datapath.sv
rtl/signed_int_to_decimal_text_top.sv
rtl/sitd_checker.sv
test/signed_int_to_decimal_text_top_tb.sv
